>>> design/m4inv_pkg.sv
// Package for the 4x4 matrix inverse: widths, states, product program decode.
`timescale 1ns / 1ps
`default_nettype none
package m4inv_pkg;

  localparam int ELEM_W    = 32;               // element width, Q16.16
  localparam int FRAC_BITS = 16;
  localparam int SCR_W     = 99;               // 2x2 minors and cofactors
  localparam int ACC_W     = 134;              // determinant and accumulator
  localparam int CHUNK_W   = 35;               // slice of the wide operand
  localparam int PROD_W    = ELEM_W + CHUNK_W; // one multiplier product
  localparam int DIV_W     = 168;              // divider datapath
  localparam int Q_W       = ELEM_W + 1;       // quotient bits produced
  localparam int DIV_SHIFT = 2 * FRAC_BITS + 1;
  localparam int SCR_DEPTH = 28;

  localparam logic [4:0] COF_BASE   = 5'd12;
  localparam logic [4:0] UPPER_BASE = 5'd6;
  localparam logic [3:0] MIN_LAST   = 4'd11;
  localparam logic [3:0] COF_LAST   = 4'd15;
  localparam logic [3:0] MIN_UPPER  = 4'd6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MIN,
    ST_COF,
    ST_DET,
    ST_WAIT,
    ST_DLOAD,
    ST_DSETUP,
    ST_DITER,
    ST_DSTORE,
    ST_OUT
  } state_t;

  // One product of the multiply-accumulate program
  typedef struct packed {
    logic [1:0] a_row;
    logic [1:0] a_col;
    logic       b_elem;
    logic [1:0] b_row;
    logic [1:0] b_col;
    logic [4:0] s_addr;
    logic       neg;
    logic       last;
    logic [4:0] dest;
  } op_t;

  // Control that travels with a product through the pipeline
  typedef struct packed {
    logic       vld;
    logic [1:0] a_col;
    logic [1:0] b_col;
    logic       b_elem;
    logic       top;
    logic [1:0] chunk;
    logic       first;
    logic       last;
    logic       neg;
    logic       to_det;
    logic [4:0] dest;
  } mac_ctl_t;

  // Column pair of a 2x2 minor, returned as {j, k}
  function automatic logic [3:0] pair_cols(input logic [2:0] p);
    case (p)
      3'd0:    pair_cols = {2'd0, 2'd1};
      3'd1:    pair_cols = {2'd0, 2'd2};
      3'd2:    pair_cols = {2'd0, 2'd3};
      3'd3:    pair_cols = {2'd1, 2'd2};
      3'd4:    pair_cols = {2'd1, 2'd3};
      default: pair_cols = {2'd2, 2'd3};
    endcase
  endfunction

  // Minor index of a column pair x < y
  function automatic logic [2:0] pair_idx(input logic [1:0] x, input logic [1:0] y);
    case ({x, y})
      4'b0001: pair_idx = 3'd0;
      4'b0010: pair_idx = 3'd1;
      4'b0011: pair_idx = 3'd2;
      4'b0110: pair_idx = 3'd3;
      4'b0111: pair_idx = 3'd4;
      default: pair_idx = 3'd5;
    endcase
  endfunction

  // Columns left when one column is removed, as {a, b, d}
  function automatic logic [5:0] other_cols(input logic [1:0] r);
    case (r)
      2'd0:    other_cols = {2'd1, 2'd2, 2'd3};
      2'd1:    other_cols = {2'd0, 2'd2, 2'd3};
      2'd2:    other_cols = {2'd0, 2'd1, 2'd3};
      default: other_cols = {2'd0, 2'd1, 2'd2};
    endcase
  endfunction

  // Decode one product of the program from phase, item and term
  function automatic op_t prog_op(input state_t st, input logic [3:0] item,
                                  input logic [1:0] term);
    op_t        op;
    logic [2:0] pr;
    logic [3:0] jk;
    logic [5:0] oc;
    logic [1:0] r;
    logic [1:0] c;
    logic [4:0] mbase;
    op    = '0;
    pr    = (item >= MIN_UPPER) ? 3'(item - MIN_UPPER) : item[2:0];
    jk    = pair_cols(pr);
    r     = item[3:2];
    c     = item[1:0];
    oc    = other_cols(r);
    mbase = c[1] ? UPPER_BASE : 5'd0;
    case (st)
      ST_MIN: begin
        // minors of rows 2,3 first, then rows 0,1
        op.a_row  = (item >= MIN_UPPER) ? 2'd0 : 2'd2;
        op.b_row  = (item >= MIN_UPPER) ? 2'd1 : 2'd3;
        op.b_elem = 1'b1;
        op.a_col  = term[0] ? jk[1:0] : jk[3:2];
        op.b_col  = term[0] ? jk[3:2] : jk[1:0];
        op.neg    = term[0];
        op.last   = term[0];
        op.dest   = {1'b0, item};
      end
      ST_COF: begin
        // expand the 3x3 minor along the row paired with c
        op.a_row = c ^ 2'd1;
        case (term)
          2'd0: begin
            op.a_col  = oc[5:4];
            op.s_addr = mbase + {2'b00, pair_idx(oc[3:2], oc[1:0])};
          end
          2'd1: begin
            op.a_col  = oc[3:2];
            op.s_addr = mbase + {2'b00, pair_idx(oc[5:4], oc[1:0])};
          end
          default: begin
            op.a_col  = oc[1:0];
            op.s_addr = mbase + {2'b00, pair_idx(oc[5:4], oc[3:2])};
          end
        endcase
        op.neg  = (term == 2'd1) ^ r[0] ^ c[0];
        op.last = (term == 2'd2);
        op.dest = COF_BASE + {1'b0, item};
      end
      ST_DET: begin
        op.a_row  = 2'd0;
        op.a_col  = term;
        op.s_addr = COF_BASE + {1'b0, term, 2'b00};
        op.last   = (term == 2'd3);
      end
      default: ;
    endcase
    prog_op = op;
  endfunction

endpackage
`default_nettype wire

>>> design/matrix4x4_inverse_top.sv
// Top level of the 4x4 matrix inverse: row store, shared multiplier, divider.
`timescale 1ns / 1ps
`default_nettype none
// Inverts a 4x4 matrix of signed Q16.16 elements sent as four input rows. Rows
// one to three are written to the row memory as they arrive. The fourth row
// starts the computation on one shared 32x35 multiplier: 2x2 minors, then
// cofactors, then the determinant (each wide operand in three slices), with a
// drain after each phase. Each of the 16 inverse elements then goes through
// a restoring divider (one quotient bit per cycle, 33 bits); for a singular
// matrix the divider steps are skipped and each element is zero. The inverse leaves
// as four beats, row 0 first; no new row is taken until the last one is taken.
module matrix4x4_inverse_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // col0, col1, col2, col3
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [127:0]      out_tdata,  // out0, out1, out2, out3
  output logic [3:0]        out_tuser,  // row_number[1:0], singular, saturated
  output logic              out_tlast   // final_row
);
  import m4inv_pkg::*;

  state_t state_r, state_nxt, nph_r;
  logic [1:0] wait_r, rows_r, term_r, chunk_r;
  logic [3:0] item_r;
  logic [5:0] bit_r;

  logic [127:0] elem_mem [0:3];
  logic [127:0] ea_q, eb_q;
  logic [SCR_W-1:0] scr_mem [0:SCR_DEPTH-1];
  logic [SCR_W-1:0] sc_q;
  logic [4:0] scr_raddr;
  logic scr_we;

  op_t op;
  logic issue, in_acc, out_beat, chunk_last, item_done, phase_done;
  mac_ctl_t p1_r, p2_r;

  logic signed [ELEM_W-1:0]  ea_s, eb_s;
  logic signed [SCR_W-1:0]   bwide;
  logic signed [CHUNK_W-1:0] cb_s;
  logic signed [PROD_W-1:0]  prod_nxt, prod_r;
  logic signed [ACC_W-1:0]   ext, shifted, acc_nxt, acc_r, det_r;

  logic [DIV_W-1:0] dabs_r, num_r, dsh_r, num_nxt;
  logic [SCR_W-1:0] cabs;
  logic cneg, dneg_r, dzero_r, ovf_r, qneg_r, ge, sat;
  logic [Q_W-1:0] q_r, lim, mag;
  logic [ELEM_W-1:0] val;
  logic [ELEM_W-1:0] row_r [0:3];
  logic rsat_r;

  // Select one element of a stored row
  function automatic logic [ELEM_W-1:0] col_sel(input logic [127:0] row,
                                                input logic [1:0] col);
    case (col)
      2'd0:    col_sel = row[31:0];
      2'd1:    col_sel = row[63:32];
      2'd2:    col_sel = row[95:64];
      default: col_sel = row[127:96];
    endcase
  endfunction

  // Issue decode
  always_comb begin
    op         = prog_op(state_r, item_r, term_r);
    issue      = (state_r == ST_MIN) || (state_r == ST_COF) || (state_r == ST_DET);
    chunk_last = op.b_elem ? 1'b1 : (chunk_r == 2'd2);
    item_done  = chunk_last && op.last;
    case (state_r)
      ST_MIN:  phase_done = item_done && (item_r == MIN_LAST);
      ST_COF:  phase_done = item_done && (item_r == COF_LAST);
      default: phase_done = item_done;
    endcase
  end

  // Port and memory control
  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    out_tvalid = (state_r == ST_OUT);
    in_acc     = in_tvalid && in_tready;
    out_beat   = out_tvalid && out_tready;
    scr_raddr  = (state_r == ST_DLOAD) ? COF_BASE + {1'b0, item_r} : op.s_addr;
    scr_we     = p2_r.vld && p2_r.last && !p2_r.to_det;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_acc && rows_r == 2'd3) state_nxt = ST_MIN;
      ST_MIN,
      ST_COF,
      ST_DET:    if (phase_done) state_nxt = ST_WAIT;
      ST_WAIT:   if (wait_r == 2'd0) state_nxt = nph_r;
      ST_DLOAD:  state_nxt = ST_DSETUP;
      ST_DSETUP: state_nxt = dzero_r ? ST_DSTORE : ST_DITER;
      ST_DITER:  if (bit_r == 6'd0) state_nxt = ST_DSTORE;
      ST_DSTORE: state_nxt = (item_r[1:0] == 2'd3) ? ST_OUT : ST_DLOAD;
      ST_OUT:    if (out_beat) state_nxt = (item_r == COF_LAST) ? ST_IDLE : ST_DLOAD;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      nph_r   <= ST_IDLE;
      wait_r  <= '0;
      rows_r  <= '0;
      item_r  <= '0;
      term_r  <= '0;
      chunk_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) rows_r <= rows_r + 2'd1;
      if (issue) begin
        chunk_r <= chunk_last ? 2'd0 : chunk_r + 2'd1;
        if (chunk_last) term_r <= op.last ? 2'd0 : term_r + 2'd1;
        if (item_done) item_r <= phase_done ? 4'd0 : item_r + 4'd1;
        if (phase_done) begin
          wait_r <= 2'd2;
          case (state_r)
            ST_MIN:  nph_r <= ST_COF;
            ST_COF:  nph_r <= ST_DET;
            default: nph_r <= ST_DLOAD;
          endcase
        end
      end
      if (state_r == ST_WAIT) wait_r <= wait_r - 2'd1;
      if (state_r == ST_DSTORE && item_r[1:0] != 2'd3) item_r <= item_r + 4'd1;
      if (out_beat) item_r <= item_r + 4'd1;
    end
  end

  // Row memory: one row written per beat, two rows read
  always_ff @(posedge clk) begin
    if (in_acc) elem_mem[rows_r] <= in_tdata;
    ea_q <= elem_mem[op.a_row];
    eb_q <= elem_mem[op.b_row];
  end

  // Scratch memory for minors and cofactors
  always_ff @(posedge clk) begin
    if (scr_we) scr_mem[p2_r.dest] <= acc_nxt[SCR_W-1:0];
    sc_q <= scr_mem[scr_raddr];
  end

  // Multiply stage: pick operands and one slice of the wide operand
  always_comb begin
    ea_s  = col_sel(ea_q, p1_r.a_col);
    eb_s  = col_sel(eb_q, p1_r.b_col);
    bwide = p1_r.b_elem ? SCR_W'(eb_s) : sc_q;
    case (p1_r.chunk)
      2'd0:    cb_s = p1_r.top ? bwide[CHUNK_W-1:0]
                               : {{(CHUNK_W-ELEM_W){1'b0}}, bwide[31:0]};
      2'd1:    cb_s = {{(CHUNK_W-ELEM_W){1'b0}}, bwide[63:32]};
      default: cb_s = bwide[SCR_W-1:64];
    endcase
    prod_nxt = ea_s * cb_s;
  end

  // Accumulate stage: align the product and add or subtract
  always_comb begin
    ext = ACC_W'(prod_r);
    case (p2_r.chunk)
      2'd0:    shifted = ext;
      2'd1:    shifted = ext <<< 32;
      default: shifted = ext <<< 64;
    endcase
    acc_nxt = (p2_r.first ? '0 : acc_r) + (p2_r.neg ? -shifted : shifted);
  end

  // Advance the multiply pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r <= '0;
      p2_r <= '0;
    end else begin
      p1_r.vld    <= issue;
      p1_r.a_col  <= op.a_col;
      p1_r.b_col  <= op.b_col;
      p1_r.b_elem <= op.b_elem;
      p1_r.top    <= chunk_last;
      p1_r.chunk  <= chunk_r;
      p1_r.first  <= (term_r == 2'd0) && (chunk_r == 2'd0);
      p1_r.last   <= item_done;
      p1_r.neg    <= op.neg;
      p1_r.to_det <= (state_r == ST_DET);
      p1_r.dest   <= op.dest;
      p2_r        <= p1_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (p2_r.vld) acc_r <= acc_nxt;
    if (p2_r.vld && p2_r.last && p2_r.to_det) det_r <= acc_nxt;
  end

  // Divider datapath
  always_comb begin
    cneg    = sc_q[SCR_W-1];
    cabs    = cneg ? (~sc_q + SCR_W'(1)) : sc_q;
    num_nxt = (DIV_W'(cabs) << DIV_SHIFT) + dabs_r;
    ge      = (num_r >= dsh_r);
    lim     = qneg_r ? (Q_W'(1) << (ELEM_W - 1)) : ((Q_W'(1) << (ELEM_W - 1)) - Q_W'(1));
    sat     = !dzero_r && (ovf_r || (q_r > lim));
    mag     = sat ? lim : q_r;
    val     = dzero_r ? '0 : (qneg_r ? ELEM_W'(-mag) : mag[ELEM_W-1:0]);
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_DLOAD: begin
        dneg_r  <= det_r[ACC_W-1];
        dzero_r <= (det_r == '0);
        dabs_r  <= DIV_W'(det_r[ACC_W-1] ? -det_r : det_r);
      end
      ST_DSETUP: begin
        num_r  <= num_nxt;
        dsh_r  <= dabs_r << DIV_SHIFT;
        ovf_r  <= (num_nxt >= (dabs_r << (DIV_SHIFT + 1)));
        qneg_r <= cneg ^ dneg_r;
        q_r    <= '0;
        bit_r  <= 6'(Q_W - 1);
      end
      ST_DITER: begin
        if (ge) num_r <= num_r - dsh_r;
        q_r   <= {q_r[Q_W-2:0], ge};
        dsh_r <= dsh_r >> 1;
        bit_r <= bit_r - 6'd1;
      end
      ST_DSTORE: begin
        row_r[item_r[1:0]] <= val;
        rsat_r <= ((item_r[1:0] == 2'd0) ? 1'b0 : rsat_r) | sat;
      end
      default: ;
    endcase
  end

  // Result beat
  assign out_tdata = {row_r[3], row_r[2], row_r[1], row_r[0]};
  assign out_tuser = {rsat_r, dzero_r, item_r[3:2]};
  assign out_tlast = (item_r[3:2] == 2'd3);

endmodule
`default_nettype wire

>>> design/m4inv_checker.sv
// Port checker for the 4x4 matrix inverse and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module m4inv_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [127:0] out_tdata,
  input wire logic [3:0]   out_tuser,
  input wire logic         out_tlast
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // Never take a row while the inverse is being delivered
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while result pending");

  // Singular rows are all zero and never clipped
  a_sing: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tdata == 128'd0 && !out_tuser[3])
    else $error("singular row not zero");

  // Last flag marks row three only
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tlast == (out_tuser[1:0] == 2'd3))
    else $error("final row flag wrong");

  // Stay busy between rows of one inverse
  a_rows: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> !in_tready)
    else $error("input ready before last row left");

endmodule

bind matrix4x4_inverse_top m4inv_checker u_m4inv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire
